@@ rtl/ssst_pkg.sv @@
`default_nettype none

package ssst_pkg;

   // item field widths
   localparam int KIND_W     = 3;
   localparam int CPU_W      = 2;
   localparam int SLOT_ID_W  = 4;
   localparam int BYTES_W    = 13;
   localparam int CNT_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int CFG_W      = 4;

   // stream bus widths
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 1;

   localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = 4'd8;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOOP    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ILLEGAL = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC     = 3'd0,
      KIND_SPECULATE = 3'd1,
      KIND_COMMIT    = 3'd2,
      KIND_DISCARD   = 3'd3,
      KIND_CLEAN     = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_INACTIVE    = 3'd0,
      ST_ACTIVE      = 3'd1,
      ST_ACTIVE_ONE  = 3'd2,
      ST_ACTIVE_MANY = 3'd3,
      ST_COMMITTING  = 3'd4,
      ST_COMMIT_MANY = 3'd5,
      ST_DISCARDING  = 3'd6
   } slot_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic scan_step;
      logic alloc_hit;
      logic alloc_miss;
      logic exec;
      logic mark;
      logic walk_step;
      logic clean_none;
      logic clean_final;
   } ssst_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_alloc;
      logic is_clean;
      logic scan_done;
      logic scan_hit;
      logic any_marked;
      logic walk_emit;
      logic walk_last;
      logic out_free;
   } ssst_sts_type;

endpackage

`default_nettype wire

@@ rtl/ssst_ctrl.sv @@
`default_nettype none

module ssst_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire ssst_pkg::ssst_sts_type sts,
   output ssst_pkg::ssst_cmd_type    cmd
);
   import ssst_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DECODE = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_EXEC   = 7'b0001000,
      S_MARK   = 7'b0010000,
      S_WALK   = 7'b0100000,
      S_FINAL  = 7'b1000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_alloc) begin
               state_in = S_SCAN;
            end else if (sts.is_clean) begin
               state_in = S_MARK;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               if (sts.out_free) begin
                  cmd.alloc_miss = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (sts.scan_hit) begin
               if (sts.out_free) begin
                  cmd.alloc_hit = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_EXEC: begin
            if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MARK: begin
            if (!sts.any_marked) begin
               if (sts.out_free) begin
                  cmd.clean_none = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               cmd.mark = 1'b1;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // stall only when this entry produces a copy request
            if (!sts.walk_emit || sts.out_free) begin
               cmd.walk_step = 1'b1;
               if (sts.walk_last) begin
                  state_in = S_FINAL;
               end
            end
         end
         S_FINAL: begin
            if (sts.out_free) begin
               cmd.clean_final = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_hit || cmd.alloc_miss || cmd.exec || cmd.clean_none || cmd.clean_final)
      |-> sts.out_free)
      else $error("result issued while output register full");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");
`endif

endmodule

`default_nettype wire

@@ rtl/ssst_dp.sv @@
`default_nettype none

module ssst_dp #(
   parameter int SLOTS        = 8,
   parameter int CPUS         = 4,
   parameter int BUFFER_BYTES = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [ssst_pkg::CFG_W-1:0]          csr_wr_data,
   input  wire logic [ssst_pkg::KIND_W-1:0]         req_kind,
   input  wire logic [ssst_pkg::CPU_W-1:0]          req_cpu,
   input  wire logic [ssst_pkg::SLOT_ID_W-1:0]      req_slot_id,
   input  wire logic [ssst_pkg::BYTES_W-1:0]        req_record_bytes,
   input  wire ssst_pkg::ssst_cmd_type              cmd,
   output ssst_pkg::ssst_sts_type                   sts,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [ssst_pkg::STATUS_W-1:0]            rsp_status,
   output logic [ssst_pkg::SLOT_ID_W-1:0]           rsp_result_slot,
   output logic                                     rsp_copy_valid,
   output logic [ssst_pkg::CPU_W-1:0]               rsp_copy_cpu,
   output logic [ssst_pkg::BYTES_W-1:0]             rsp_copy_length,
   output logic [ssst_pkg::CNT_W-1:0]               rsp_busy_fails,
   output logic [ssst_pkg::CNT_W-1:0]               rsp_unavail_fails,
   output logic                                     rsp_last
);
   import ssst_pkg::*;

   localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = (CPUS > 1) ? $clog2(CPUS) : 1;
   localparam int FW   = $clog2(BUFFER_BYTES + 1);
   localparam int SUMW = ((FW > BYTES_W) ? FW : BYTES_W) + 1;
   localparam logic [SLOT_ID_W-1:0] SLOTS_ID  = SLOT_ID_W'(SLOTS);
   localparam logic [CPU_W:0]       CPU_LIM   = (CPU_W + 1)'(CPUS);
   localparam logic [SW-1:0]        LAST_SLOT = SW'(SLOTS - 1);
   localparam logic [CW-1:0]        LAST_CPU  = CW'(CPUS - 1);

   // configuration and table state
   logic [CFG_W-1:0]     active_slots_ff, active_slots_in;
   slot_state_type       slot_state_ff [SLOTS];
   slot_state_type       slot_state_in [SLOTS];
   logic [FW-1:0]        fill_ff [SLOTS][CPUS];
   logic [FW-1:0]        fill_in [SLOTS][CPUS];
   logic [CNT_W-1:0]     busy_cnt_ff, busy_cnt_in;
   logic [CNT_W-1:0]     unavail_cnt_ff, unavail_cnt_in;

   // item being worked on
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [CPU_W-1:0]     cpu_ff, cpu_in;
   logic [SLOT_ID_W-1:0] sid_ff, sid_in;
   logic [BYTES_W-1:0]   bytes_ff, bytes_in;

   // scan / walk counters
   logic [SLOT_ID_W-1:0] scan_idx_ff, scan_idx_in;
   logic                 scan_busy_ff, scan_busy_in;
   logic [SLOTS-1:0]     marked_ff, marked_in;
   logic [SW-1:0]        walk_slot_ff, walk_slot_in;
   logic [CW-1:0]        walk_cpu_ff, walk_cpu_in;

   // result register
   logic                 valid_ff, valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [SLOT_ID_W-1:0] slot_ff, slot_in;
   logic                 cv_ff, cv_in;
   logic [CPU_W-1:0]     ccpu_ff, ccpu_in;
   logic [BYTES_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]     busy_o_ff, busy_o_in;
   logic [CNT_W-1:0]     unavail_o_ff, unavail_o_in;
   logic                 last_ff, last_in;

   logic [SLOT_ID_W-1:0] n_eff;
   logic [SW-1:0]        sidx;
   logic [CW-1:0]        cidx;
   logic [STATUS_W-1:0]  chk;
   slot_state_type       st_cur, st_scan, st_walk, ex_state;
   logic [FW-1:0]        f_cur, f_walk, f_sat, ex_fill;
   logic [SUMW-1:0]      sum;
   logic                 ex_grant, ex_copy, is_op;
   logic [STATUS_W-1:0]  ex_status;
   logic [SLOTS-1:0]     mark_vec;
   logic                 emit, walk_emit;

   assign n_eff  = (active_slots_ff < SLOTS_ID) ? active_slots_ff : SLOTS_ID;
   assign sidx   = SW'(sid_ff - SLOT_ID_W'(1));
   assign cidx   = CW'(cpu_ff);
   assign st_cur = slot_state_ff[sidx];
   assign f_cur  = fill_ff[sidx][cidx];
   assign st_scan = slot_state_ff[scan_idx_ff[SW-1:0]];
   assign st_walk = slot_state_ff[walk_slot_ff];
   assign f_walk  = fill_ff[walk_slot_ff][walk_cpu_ff];

   // operand check: zero id, id beyond table, cpu beyond CPUS
   always_comb begin
      if (sid_ff == '0) begin
         chk = STAT_NOOP;
      end else if (sid_ff > n_eff) begin
         chk = STAT_ILLEGAL;
      end else if ({1'b0, cpu_ff} >= CPU_LIM) begin
         chk = STAT_NOOP;
      end else begin
         chk = STAT_DONE;
      end
   end

   assign sum   = SUMW'(f_cur) + SUMW'(bytes_ff);
   assign f_sat = (sum > SUMW'(BUFFER_BYTES)) ? FW'(BUFFER_BYTES) : FW'(sum);
   assign is_op = (kind_ff == KIND_SPECULATE) || (kind_ff == KIND_COMMIT) ||
                  (kind_ff == KIND_DISCARD);

   // speculate / commit / discard decision
   always_comb begin
      ex_grant  = 1'b0;
      ex_copy   = 1'b0;
      ex_state  = st_cur;
      ex_fill   = f_cur;
      ex_status = STAT_NOOP;
      if (is_op && chk != STAT_DONE) begin
         ex_status = chk;
      end else if (is_op) begin
         case (kind_ff)
            KIND_SPECULATE: begin
               ex_fill = f_sat;
               case (st_cur)
                  ST_ACTIVE: begin
                     ex_grant = 1'b1;
                     ex_state = ST_ACTIVE_ONE;
                  end
                  ST_ACTIVE_ONE: begin
                     ex_grant = 1'b1;
                     if (f_cur == '0) begin
                        ex_state = ST_ACTIVE_MANY;
                     end
                  end
                  ST_ACTIVE_MANY: begin
                     ex_grant = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            KIND_COMMIT: begin
               ex_fill = '0;
               case (st_cur)
                  ST_ACTIVE: begin
                     ex_grant = 1'b1;
                     ex_state = ST_INACTIVE;
                  end
                  ST_ACTIVE_ONE: begin
                     ex_grant = 1'b1;
                     ex_state = (f_cur != '0) ? ST_INACTIVE : ST_COMMIT_MANY;
                  end
                  ST_ACTIVE_MANY: begin
                     ex_grant = 1'b1;
                     ex_state = ST_COMMIT_MANY;
                  end
                  ST_COMMIT_MANY: begin
                     ex_grant = 1'b1;
                  end
                  default: begin
                  end
               endcase
               ex_copy = ex_grant;
            end
            KIND_DISCARD: begin
               ex_fill = '0;
               case (st_cur)
                  ST_ACTIVE, ST_ACTIVE_MANY: begin
                     ex_grant = 1'b1;
                     ex_state = ST_DISCARDING;
                  end
                  ST_ACTIVE_ONE: begin
                     ex_grant = 1'b1;
                     ex_state = (f_cur != '0) ? ST_INACTIVE : ST_DISCARDING;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
         if (ex_grant) begin
            ex_status = STAT_DONE;
         end
      end
   end

   // slots to flush on clean
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         mark_vec[i] = (SLOT_ID_W'(i) < n_eff) &&
                       (slot_state_ff[i] == ST_DISCARDING ||
                        slot_state_ff[i] == ST_COMMIT_MANY);
      end
   end

   assign walk_emit = marked_ff[walk_slot_ff] && (st_walk == ST_COMMIT_MANY) &&
                      (f_walk != '0);

   assign sts.is_alloc   = (kind_ff == KIND_ALLOC);
   assign sts.is_clean   = (kind_ff == KIND_CLEAN);
   assign sts.scan_done  = (scan_idx_ff >= n_eff);
   assign sts.scan_hit   = (st_scan == ST_INACTIVE);
   assign sts.any_marked = |mark_vec;
   assign sts.walk_emit  = walk_emit;
   assign sts.walk_last  = (walk_slot_ff == LAST_SLOT) && (walk_cpu_ff == LAST_CPU);
   assign sts.out_free   = !valid_ff || rsp_ready;

   assign emit = cmd.alloc_hit || cmd.alloc_miss || cmd.exec || cmd.clean_none ||
                 cmd.clean_final || (cmd.walk_step && walk_emit);

   always_comb begin
      active_slots_in = csr_wr_en ? csr_wr_data : active_slots_ff;
      slot_state_in   = slot_state_ff;
      fill_in         = fill_ff;
      busy_cnt_in     = busy_cnt_ff;
      unavail_cnt_in  = unavail_cnt_ff;
      kind_in         = kind_ff;
      cpu_in          = cpu_ff;
      sid_in          = sid_ff;
      bytes_in        = bytes_ff;
      scan_idx_in     = scan_idx_ff;
      scan_busy_in    = scan_busy_ff;
      marked_in       = marked_ff;
      walk_slot_in    = walk_slot_ff;
      walk_cpu_in     = walk_cpu_ff;

      if (cmd.load) begin
         kind_in      = req_kind;
         cpu_in       = req_cpu;
         sid_in       = req_slot_id;
         bytes_in     = req_record_bytes;
         scan_idx_in  = '0;
         scan_busy_in = 1'b0;
      end
      if (cmd.scan_step) begin
         scan_idx_in  = scan_idx_ff + SLOT_ID_W'(1);
         scan_busy_in = scan_busy_ff || st_scan == ST_COMMIT_MANY ||
                        st_scan == ST_COMMITTING || st_scan == ST_DISCARDING;
      end
      if (cmd.alloc_hit) begin
         slot_state_in[scan_idx_ff[SW-1:0]] = ST_ACTIVE;
      end
      if (cmd.alloc_miss) begin
         if (scan_busy_ff) begin
            busy_cnt_in = busy_cnt_ff + CNT_W'(1);
         end else begin
            unavail_cnt_in = unavail_cnt_ff + CNT_W'(1);
         end
      end
      if (cmd.exec && ex_grant) begin
         slot_state_in[sidx] = ex_state;
         fill_in[sidx][cidx] = ex_fill;
      end
      if (cmd.mark) begin
         marked_in    = mark_vec;
         walk_slot_in = '0;
         walk_cpu_in  = '0;
      end
      if (cmd.walk_step) begin
         if (marked_ff[walk_slot_ff]) begin
            fill_in[walk_slot_ff][walk_cpu_ff] = '0;
         end
         if (walk_slot_ff == LAST_SLOT) begin
            walk_slot_in = '0;
            walk_cpu_in  = walk_cpu_ff + CW'(1);
         end else begin
            walk_slot_in = walk_slot_ff + SW'(1);
         end
      end
      if (cmd.clean_final) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (marked_ff[i]) begin
               slot_state_in[i] = ST_INACTIVE;
            end
         end
      end
   end

   // result register load
   always_comb begin
      valid_in     = emit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      status_in    = status_ff;
      slot_in      = slot_ff;
      cv_in        = cv_ff;
      ccpu_in      = ccpu_ff;
      len_in       = len_ff;
      busy_o_in    = busy_o_ff;
      unavail_o_in = unavail_o_ff;
      last_in      = last_ff;
      if (emit) begin
         status_in    = STAT_DONE;
         slot_in      = '0;
         cv_in        = 1'b0;
         ccpu_in      = '0;
         len_in       = '0;
         busy_o_in    = busy_cnt_in;
         unavail_o_in = unavail_cnt_in;
         last_in      = 1'b1;
         if (cmd.alloc_hit) begin
            slot_in = scan_idx_ff + SLOT_ID_W'(1);
         end
         if (cmd.alloc_miss || cmd.clean_none) begin
            status_in = STAT_NOOP;
         end
         if (cmd.exec) begin
            status_in = ex_status;
            if (ex_copy) begin
               slot_in = sid_ff;
               cv_in   = 1'b1;
               ccpu_in = cpu_ff;
               len_in  = BYTES_W'(f_cur);
            end
         end
         if (cmd.walk_step) begin
            slot_in = SLOT_ID_W'(walk_slot_ff) + SLOT_ID_W'(1);
            cv_in   = 1'b1;
            ccpu_in = CPU_W'(walk_cpu_ff);
            len_in  = BYTES_W'(f_walk);
            last_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_slots_ff <= ACTIVE_SLOTS_RESET;
         busy_cnt_ff     <= '0;
         unavail_cnt_ff  <= '0;
         valid_ff        <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_state_ff[i] <= ST_INACTIVE;
            for (int c = 0; c < CPUS; c++) begin
               fill_ff[i][c] <= '0;
            end
         end
      end else begin
         active_slots_ff <= active_slots_in;
         busy_cnt_ff     <= busy_cnt_in;
         unavail_cnt_ff  <= unavail_cnt_in;
         valid_ff        <= valid_in;
         slot_state_ff   <= slot_state_in;
         fill_ff         <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      cpu_ff       <= cpu_in;
      sid_ff       <= sid_in;
      bytes_ff     <= bytes_in;
      scan_idx_ff  <= scan_idx_in;
      scan_busy_ff <= scan_busy_in;
      marked_ff    <= marked_in;
      walk_slot_ff <= walk_slot_in;
      walk_cpu_ff  <= walk_cpu_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
      cv_ff        <= cv_in;
      ccpu_ff      <= ccpu_in;
      len_ff       <= len_in;
      busy_o_ff    <= busy_o_in;
      unavail_o_ff <= unavail_o_in;
      last_ff      <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_result_slot   = slot_ff;
   assign rsp_copy_valid    = cv_ff;
   assign rsp_copy_cpu      = ccpu_ff;
   assign rsp_copy_length   = len_ff;
   assign rsp_busy_fails    = busy_o_ff;
   assign rsp_unavail_fails = unavail_o_ff;
   assign rsp_last          = last_ff;

`ifndef ASSERT_OFF
   a_copy_has_slot: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && cv_ff) |-> (slot_ff != '0))
      else $error("copy request without a slot");
   a_counters_move_on_miss: assert property (@(posedge clock) disable iff (reset)
      !cmd.alloc_miss |=> ($stable(busy_cnt_ff) && $stable(unavail_cnt_ff)))
      else $error("failure counter changed without an allocation miss");
`endif

endmodule

`default_nettype wire

@@ rtl/speculation_slot_state_table_top.sv @@
// Flow: an item is accepted and decoded; speculate/commit/discard/other kinds then issue
//   a result; allocate scans one slot per cycle, at most min(active_slots, SLOTS) slots.
// Clean: marks slots, walks all SLOTS*CPUS fill entries (one per step), then a closing
//   step; with nothing marked a single result. Output stalls hold result-issuing steps.
// Throughput: one item in flight. Reset: synchronous, active high; slots inactive,
//   fill counts and counters zero, active_slots 8, ready at once.
`default_nettype none

module speculation_slot_state_table_top #(
   parameter int SLOTS        = 8,
   parameter int CPUS         = 4,
   parameter int BUFFER_BYTES = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration: active_slots
   input  wire logic                               csr_wr_en,
   input  wire logic [ssst_pkg::CFG_W-1:0]         csr_wr_data,
   // operation items
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // cpu[1:0], slot_id[5:2], record_bytes[18:6], zero pad [23:19]
   input  wire logic [ssst_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind[2:0]
   input  wire logic [ssst_pkg::REQ_USER_W-1:0]    req_tuser,
   // result items
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // status[1:0], result_slot[5:2], copy_cpu[7:6], copy_length[20:8],
   // busy_fails[52:21], unavail_fails[84:53], zero pad [87:85]
   output logic [ssst_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   // copy_valid[0]
   output logic [ssst_pkg::RSP_USER_W-1:0]         rsp_tuser,
   output logic                                    rsp_tlast
);
   import ssst_pkg::*;

   ssst_cmd_type cmd;
   ssst_sts_type sts;

   // unpacked result fields
   logic [STATUS_W-1:0]  rsp_status;
   logic [SLOT_ID_W-1:0] rsp_result_slot;
   logic                 rsp_copy_valid;
   logic [CPU_W-1:0]     rsp_copy_cpu;
   logic [BYTES_W-1:0]   rsp_copy_length;
   logic [CNT_W-1:0]     rsp_busy_fails;
   logic [CNT_W-1:0]     rsp_unavail_fails;

   // Sequencer: one item at a time; decides scan / exec / clean walk steps
   // and holds off issuing a result while the output register is full.
   ssst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Slot table, fill counts, failure counters and the result register.
   ssst_dp #(
      .SLOTS        (SLOTS),
      .CPUS         (CPUS),
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_kind          (req_tuser[KIND_W-1:0]),
      .req_cpu           (req_tdata[1:0]),
      .req_slot_id       (req_tdata[5:2]),
      .req_record_bytes  (req_tdata[18:6]),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_status        (rsp_status),
      .rsp_result_slot   (rsp_result_slot),
      .rsp_copy_valid    (rsp_copy_valid),
      .rsp_copy_cpu      (rsp_copy_cpu),
      .rsp_copy_length   (rsp_copy_length),
      .rsp_busy_fails    (rsp_busy_fails),
      .rsp_unavail_fails (rsp_unavail_fails),
      .rsp_last          (rsp_tlast)
   );

   // pack result fields, lowest field in the low bits
   assign rsp_tdata = {3'b000, rsp_unavail_fails, rsp_busy_fails, rsp_copy_length,
                       rsp_copy_cpu, rsp_result_slot, rsp_status};
   assign rsp_tuser = rsp_copy_valid;

endmodule

`default_nettype wire
